// ----- rtl/trie_multi_pattern_matcher_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TRIE_MULTI_PATTERN_MATCHER_ASSERT_SVH
`define TRIE_MULTI_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication under reset.
`define TMPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define TMPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tmpm_pkg.sv -----
`default_nettype none

package tmpm_pkg;

	localparam int ALPHABET    = 26;
	localparam int LETTER_W    = 5;
	localparam int FUNC_W      = 2;
	localparam int SYM_W       = 8;
	localparam int MATCH_W     = 5;
	localparam int STATUS_W    = 2;
	localparam int OUT_TDATA_W = 8;

	localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
	localparam logic [SYM_W-1:0] CHAR_Z = 8'h5A;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_END    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/trie_multi_pattern_matcher.sv -----
// Insert letter: child-table read, then follow the child or allocate a node; end of word: store the depth.
// Scan letter: read each active node's child, fetch the word length of each hit, then append the root.
// Scan non-letter: reset the active list to the root. One item at a time; ready only when idle.
// The child-table read port and the address multiply-add are shared by the whole walk.
// After reset a clearing pass zeroes the tables; no item is taken meanwhile.
`default_nettype none

module trie_multi_pattern_matcher
	import tmpm_pkg::*;
#(
	parameter int NODE_COUNT = 256,
	parameter int WORD_MAX   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [SYM_W-1:0]       s_tdata,  // [7:0] symbol
	input  wire logic [FUNC_W-1:0]      s_tuser,  // [1:0] func
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata   // [4:0] match_length, [6:5] status, [7] zero
);

	localparam int SLOTS   = NODE_COUNT * ALPHABET;
	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int NU_W    = $clog2(NODE_COUNT + 1);
	localparam int DEPTH_W = $clog2(WORD_MAX + 1);
	localparam int ACT_CAP = WORD_MAX + 1;
	localparam int ACT_W   = $clog2(WORD_MAX + 1);
	localparam int CNT_W   = $clog2(WORD_MAX + 2);

	state_t state_q, state_d;

	logic [SLOT_W-1:0]   clr_q, clr_d;
	logic [NU_W-1:0]     nodes_used_q, nodes_used_d;
	logic [NODE_W-1:0]   cursor_q, cursor_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                iss_s1, iss_d;
	logic                hit_s2, hit_d;
	logic                m_tvalid_q;

	logic [CNT_W-1:0]    i_q, i_d;
	logic [CNT_W-1:0]    n_q, n_d;
	logic [LETTER_W-1:0] letter_q, letter_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [DEPTH_W-1:0]  best_q, best_d;
	logic [MATCH_W-1:0]  res_match_q, res_match_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                load_out;

	logic [NODE_W-1:0]   act_q [ACT_CAP];
	logic                act_we;
	logic [ACT_W-1:0]    act_wa;
	logic [NODE_W-1:0]   act_wd;

	logic [NODE_W-1:0]   child_mem [SLOTS];
	logic                ct_we;
	logic [SLOT_W-1:0]   ct_wa, ct_ra;
	logic [NODE_W-1:0]   ct_wd, ct_rd;

	logic [DEPTH_W-1:0]  wl_mem [NODE_COUNT];
	logic                wl_we;
	logic [NODE_W-1:0]   wl_wa;
	logic [DEPTH_W-1:0]  wl_wd, wl_rd;

	logic                is_letter;
	logic [LETTER_W-1:0] letter_in;
	logic [NODE_W-1:0]   scan_node;
	logic [SLOT_W-1:0]   ins_slot, scan_slot;

	assign is_letter = s_tdata inside {[CHAR_A:CHAR_Z]};
	assign letter_in = LETTER_W'(s_tdata - CHAR_A);
	assign scan_node = act_q[i_q[ACT_W-1:0]];
	assign ins_slot  = SLOT_W'(SLOT_W'(cursor_q) * SLOT_W'(ALPHABET) + SLOT_W'(letter_in));
	assign scan_slot = SLOT_W'(SLOT_W'(scan_node) * SLOT_W'(ALPHABET) + SLOT_W'(letter_q));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		nodes_used_d = nodes_used_q;
		cursor_d     = cursor_q;
		depth_d      = depth_q;
		cnt_d        = cnt_q;
		iss_d        = 1'b0;
		hit_d        = 1'b0;
		i_d          = i_q;
		n_d          = n_q;
		letter_d     = letter_q;
		slot_d       = slot_q;
		best_d       = best_q;
		res_match_d  = res_match_q;
		res_status_d = res_status_q;
		load_out     = 1'b0;
		act_we       = 1'b0;
		act_wa       = '0;
		act_wd       = '0;
		ct_we        = 1'b0;
		ct_wa        = slot_q;
		ct_wd        = '0;
		ct_ra        = (state_q == ST_IDLE) ? ins_slot : scan_slot;
		wl_we        = 1'b0;
		wl_wa        = cursor_q;
		wl_wd        = '0;
		case (state_q)
			ST_CLEAR: begin
				ct_we = 1'b1;
				ct_wa = clr_q;
				wl_we = (clr_q < SLOT_W'(NODE_COUNT));
				wl_wa = clr_q[NODE_W-1:0];
				if (clr_q == SLOT_W'(SLOTS - 1)) begin
					act_we  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					res_match_d  = '0;
					res_status_d = STATUS_OK;
					state_d      = ST_DONE;
					case (s_tuser)
						FUNC_INSERT: begin
							if (!is_letter || depth_q >= DEPTH_W'(WORD_MAX)) begin
								res_status_d = STATUS_BAD;
							end else begin
								slot_d  = ins_slot;
								state_d = ST_INS;
							end
						end
						FUNC_END: begin
							wl_we    = 1'b1;
							wl_wa    = cursor_q;
							wl_wd    = depth_q;
							cursor_d = '0;
							depth_d  = '0;
						end
						FUNC_SCAN: begin
							if (!is_letter) begin
								act_we = 1'b1;
								cnt_d  = CNT_W'(1);
							end else begin
								letter_d = letter_in;
								i_d      = '0;
								n_d      = '0;
								best_d   = '0;
								state_d  = ST_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_INS: begin
				state_d = ST_DONE;
				if (ct_rd == '0) begin
					if (nodes_used_q >= NU_W'(NODE_COUNT)) begin
						res_status_d = STATUS_FULL;
					end else begin
						ct_we        = 1'b1;
						ct_wd        = nodes_used_q[NODE_W-1:0];
						cursor_d     = nodes_used_q[NODE_W-1:0];
						nodes_used_d = nodes_used_q + 1'b1;
						depth_d      = depth_q + 1'b1;
					end
				end else begin
					cursor_d = ct_rd;
					depth_d  = depth_q + 1'b1;
				end
			end
			ST_SCAN: begin
				// issue one child read per active node
				if (i_q < cnt_q) begin
					iss_d = 1'b1;
					i_d   = i_q + 1'b1;
				end
				// child back: fetch its word length, keep it as active if there is room
				if (iss_s1 && ct_rd != '0) begin
					hit_d = 1'b1;
					if (n_q < CNT_W'(WORD_MAX)) begin
						act_we = 1'b1;
						act_wa = n_q[ACT_W-1:0];
						act_wd = ct_rd;
						n_d    = n_q + 1'b1;
					end
				end
				if (hit_s2 && wl_rd > best_q) begin
					best_d = wl_rd;
				end
				// walk drained: append the root
				if (i_q == cnt_q && !iss_s1 && !hit_s2) begin
					act_we      = 1'b1;
					act_wa      = n_q[ACT_W-1:0];
					cnt_d       = n_q + 1'b1;
					res_match_d = MATCH_W'(best_q);
					state_d     = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			nodes_used_q <= NU_W'(1);
			cursor_q     <= '0;
			depth_q      <= '0;
			cnt_q        <= CNT_W'(1);
			iss_s1       <= 1'b0;
			hit_s2       <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			nodes_used_q <= nodes_used_d;
			cursor_q     <= cursor_d;
			depth_q      <= depth_d;
			cnt_q        <= cnt_d;
			iss_s1       <= iss_d;
			hit_s2       <= hit_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q          <= i_d;
		n_q          <= n_d;
		letter_q     <= letter_d;
		slot_q       <= slot_d;
		best_q       <= best_d;
		res_match_q  <= res_match_d;
		res_status_q <= res_status_d;
		if (load_out) begin
			m_tdata_q <= OUT_TDATA_W'({res_status_q, res_match_q});
		end
		if (act_we) begin
			act_q[act_wa] <= act_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ct_we) begin
			child_mem[ct_wa] <= ct_wd;
		end
		ct_rd <= child_mem[ct_ra];
	end

	always_ff @(posedge clk) begin
		if (wl_we) begin
			wl_mem[wl_wa] <= wl_wd;
		end
		wl_rd <= wl_mem[ct_rd];
	end

endmodule

`default_nettype wire

// ----- rtl/tmpm_checker.sv -----
`default_nettype none

`include "trie_multi_pattern_matcher_assert.svh"

module tmpm_checker
	import tmpm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	`TMPM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
	`TMPM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
	`TMPM_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, !(m_tdata[6] && m_tdata[5]) && !m_tdata[7], "undefined status code or pad bit set")
	`TMPM_ASSERT_NOW(a_error_no_match, clk, arst_n, m_tvalid && (m_tdata[6] || m_tdata[5]), m_tdata[4:0] == 5'd0, "match length reported with an error status")

endmodule

bind trie_multi_pattern_matcher tmpm_checker u_tmpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
